@@ src/rmq_pkg.sv @@
package rmq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int BLOCK_SIZE   = 32;
    localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

    localparam int ELEM_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ELEMENTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int OFF_W     = $clog2(BLOCK_SIZE);
    localparam int BLK_IDX_W = $clog2(NUM_BLOCKS);

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [BLK_IDX_W-1:0]     blk_idx_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_ELEM,
        S_SCAN_W,
        S_SCAN_Q,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic from_blk;
        logic init;
    } issue_t;

    typedef struct packed {
        logic     elem_we;
        idx_t     elem_waddr;
        elem_t    elem_wdata;
        idx_t     elem_raddr;
        logic     blk_we;
        blk_idx_t blk_waddr;
        elem_t    blk_wdata;
        blk_idx_t blk_raddr;
    } mem_req_t;

endpackage

@@ src/rmq_if.sv @@
interface rmq_in_if;
    logic          valid;
    logic          ready;
    logic          op;
    rmq_pkg::idx_t index;
    rmq_pkg::idx_t right_index;
    rmq_pkg::elem_t value;

    modport source (output valid, output op, output index, output right_index,
                    output value, input ready);
    modport sink   (input valid, input op, input index, input right_index,
                    input value, output ready);
endinterface

interface rmq_out_if;
    logic           valid;
    logic           ready;
    rmq_pkg::elem_t max_value;
    logic           status;

    modport source (output valid, output max_value, output status, input ready);
    modport sink   (input valid, input max_value, input status, output ready);
endinterface

@@ src/block_range_max_with_update_unit.sv @@
// Range-maximum store with point writes, organized as blocks of 32 elements
// over 1024 signed 32-bit elements. After reset the unit clears both
// memories before it takes its first transfer; configuration writes are
// taken at any time the unit is idle. Items are handled one at a time, one
// memory read per cycle: a write stores the element, rescans its block and
// writes the block maximum back, and a query reads each element in the
// partial blocks at either end and one block maximum per whole block in
// between. A rejected index goes straight to the result. The result is
// held in an output register, so a pending result does not block the next
// input transfer.
module block_range_max_with_update_unit (
    input  logic          clk,
    input  logic          rst_n,
    rmq_in_if.sink        in_ch,
    rmq_out_if.source     out_ch,
    input  logic          cfg_wr_en,
    input  rmq_pkg::cnt_t cfg_wr_data
);

    import rmq_pkg::*;

    cnt_t     element_count_reg;
    issue_t   issue;
    mem_req_t mem;
    elem_t    elem_rdata;
    elem_t    blk_rdata;
    elem_t    best;
    logic     acc_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= CNT_W'(MAX_ELEMENTS);
        end
        else if (cfg_wr_en)
        begin
            element_count_reg <= cfg_wr_data;
        end
    end

    rmq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_elem_ram (
        .clk   (clk),
        .we    (mem.elem_we),
        .waddr (mem.elem_waddr),
        .wdata (mem.elem_wdata),
        .raddr (mem.elem_raddr),
        .rdata (elem_rdata)
    );

    rmq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (NUM_BLOCKS)
    ) u_blk_ram (
        .clk   (clk),
        .we    (mem.blk_we),
        .waddr (mem.blk_waddr),
        .wdata (mem.blk_wdata),
        .raddr (mem.blk_raddr),
        .rdata (blk_rdata)
    );

    rmq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .count    (element_count_reg),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .best     (best),
        .acc_busy (acc_busy),
        .issue    (issue),
        .mem      (mem)
    );

    rmq_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .elem_rdata (elem_rdata),
        .blk_rdata  (blk_rdata),
        .best       (best),
        .busy       (acc_busy)
    );

endmodule

@@ src/rmq_ram.sv @@
module rmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/rmq_acc.sv @@
module rmq_acc (
    input  logic            clk,
    input  logic            rst_n,
    input  rmq_pkg::issue_t issue,
    input  rmq_pkg::elem_t  elem_rdata,
    input  rmq_pkg::elem_t  blk_rdata,
    output rmq_pkg::elem_t  best,
    output logic            busy
);

    import rmq_pkg::*;

    issue_t tag_reg;
    elem_t  best_reg;
    elem_t  best_next;
    elem_t  data;

    always_comb
    begin
        data      = tag_reg.from_blk ? blk_rdata : elem_rdata;
        best_next = best_reg;
        if (tag_reg.valid && (tag_reg.init || (data > best_reg)))
        begin
            best_next = data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign best = best_reg;
    assign busy = tag_reg.valid;

endmodule

@@ src/rmq_seq.sv @@
module rmq_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  rmq_pkg::cnt_t     count,
    rmq_in_if.sink            in_ch,
    rmq_out_if.source         out_ch,
    input  rmq_pkg::elem_t    best,
    input  logic              acc_busy,
    output rmq_pkg::issue_t   issue,
    output rmq_pkg::mem_req_t mem
);

    import rmq_pkg::*;

    state_t state_reg, state_next;
    idx_t   clr_reg, clr_next;
    logic   op_reg, op_next;
    logic   err_reg, err_next;
    idx_t   l_reg, l_next;
    idx_t   r_reg, r_next;
    elem_t  v_reg, v_next;
    cnt_t   p_reg, p_next;
    cnt_t   end_reg, end_next;
    logic   first_reg, first_next;
    logic   out_valid_reg, out_valid_next;
    elem_t  out_max_reg, out_max_next;
    logic   out_status_reg, out_status_next;

    cnt_t   count_use;
    cnt_t   idx_ext;
    cnt_t   ridx_ext;
    cnt_t   start_in;
    cnt_t   start_plus;
    cnt_t   r_ext;
    cnt_t   p_plus_blk;
    logic   bad;

    always_comb
    begin
        count_use  = (count > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : count;
        idx_ext    = {1'b0, in_ch.index};
        ridx_ext   = {1'b0, in_ch.right_index};
        start_in   = {1'b0, in_ch.index[IDX_W-1:OFF_W], {OFF_W{1'b0}}};
        start_plus = start_in + CNT_W'(BLOCK_SIZE);
        r_ext      = {1'b0, r_reg};
        p_plus_blk = p_reg + CNT_W'(BLOCK_SIZE);
        bad        = (idx_ext >= count_use)
                  || ((in_ch.op == OP_QUERY) && (ridx_ext >= count_use));
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        err_next        = err_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        v_next          = v_reg;
        p_next          = p_reg;
        end_next        = end_reg;
        first_next      = first_reg;
        out_valid_next  = out_valid_reg;
        out_max_next    = out_max_reg;
        out_status_next = out_status_reg;

        issue           = '0;
        mem             = '0;
        mem.elem_raddr  = p_reg[IDX_W-1:0];
        mem.blk_raddr   = p_reg[IDX_W-1:OFF_W];
        mem.elem_waddr  = l_reg;
        mem.elem_wdata  = v_reg;
        mem.blk_waddr   = l_reg[IDX_W-1:OFF_W];
        mem.blk_wdata   = best;

        in_ch.ready     = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem.elem_we    = 1'b1;
                mem.elem_waddr = clr_reg;
                mem.elem_wdata = '0;
                mem.blk_we     = 1'b1;
                mem.blk_waddr  = clr_reg[BLK_IDX_W-1:0];
                mem.blk_wdata  = '0;
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ch.ready    = 1'b1;
                mem.elem_raddr = in_ch.index;
                if (in_ch.valid)
                begin
                    op_next  = in_ch.op;
                    err_next = bad;
                    l_next   = in_ch.index;
                    r_next   = in_ch.right_index;
                    v_next   = in_ch.value;
                    p_next   = idx_ext;
                    end_next = (start_plus > count_use) ? count_use : start_plus;
                    if (bad)
                    begin
                        state_next = S_DONE;
                    end
                    else if (in_ch.op == OP_QUERY)
                    begin
                        // The left element seeds the running maximum.
                        issue.valid = 1'b1;
                        issue.init  = 1'b1;
                        state_next  = S_SCAN_Q;
                    end
                    else
                    begin
                        state_next = S_WR_ELEM;
                    end
                end
            end
            S_WR_ELEM:
            begin
                mem.elem_we = 1'b1;
                p_next      = {1'b0, l_reg[IDX_W-1:OFF_W], {OFF_W{1'b0}}};
                first_next  = 1'b1;
                state_next  = S_SCAN_W;
            end
            S_SCAN_W:
            begin
                if (p_reg < end_reg)
                begin
                    issue.valid = 1'b1;
                    issue.init  = first_reg;
                    first_next  = 1'b0;
                    p_next      = p_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_SCAN_Q:
            begin
                if ((p_reg < r_ext) && (p_reg[OFF_W-1:0] != '0))
                begin
                    issue.valid = 1'b1;
                    p_next      = p_reg + 1'b1;
                end
                else if (p_plus_blk <= r_ext)
                begin
                    issue.valid    = 1'b1;
                    issue.from_blk = 1'b1;
                    p_next         = p_plus_blk;
                end
                else if (p_reg <= r_ext)
                begin
                    issue.valid = 1'b1;
                    p_next      = p_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!acc_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                mem.blk_we = (op_reg == OP_WRITE) && !err_reg;
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_max_next    = ((op_reg == OP_QUERY) && !err_reg) ? best : '0;
                    out_status_next = err_reg ? ST_RANGE : ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        err_reg        <= err_next;
        l_reg          <= l_next;
        r_reg          <= r_next;
        v_reg          <= v_next;
        p_reg          <= p_next;
        end_reg        <= end_next;
        first_reg      <= first_next;
        out_max_reg    <= out_max_next;
        out_status_reg <= out_status_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.max_value = out_max_reg;
    assign out_ch.status    = out_status_reg;

endmodule

@@ dv/rmq_answer_check.sv @@
module rmq_answer_check (
    input  logic          clk,
    input  logic          rst_n,
    rmq_in_if             in_ch,
    rmq_out_if            out_ch,
    input  logic          cfg_wr_en,
    input  rmq_pkg::cnt_t cfg_wr_data,
    output int            answers_pending,
    output int            mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import rmq_pkg::*;

    typedef struct {
        elem_t max_value;
        logic  status;
    } answer_t;

    elem_t   elements [MAX_ELEMENTS];
    elem_t   block_peaks [NUM_BLOCKS];
    cnt_t    element_count;
    answer_t answers_due [$];
    answer_t oldest;
    int      fail_tally;

    function automatic int unsigned count_in_force();
        return (element_count > MAX_ELEMENTS) ? MAX_ELEMENTS : element_count;
    endfunction

    // A block peak is rebuilt only from the elements below the count in force at
    // the time of the write, so it may go stale after the count changes.
    function automatic void refresh_block(int unsigned pos, int unsigned limit);
        int unsigned blk;
        int unsigned first;
        int unsigned stop;
        elem_t       best;
        blk   = pos / BLOCK_SIZE;
        first = blk * BLOCK_SIZE;
        stop  = (first + BLOCK_SIZE > limit) ? limit : first + BLOCK_SIZE;
        best  = elements[first];
        for (int unsigned i = first; i < stop; i++)
        begin
            if (elements[i] > best)
                best = elements[i];
        end
        block_peaks[blk] = best;
    endfunction

    function automatic elem_t span_max(int unsigned lo, int unsigned hi);
        int unsigned p;
        elem_t       best;
        p    = lo;
        best = elements[p];
        while (p < hi && (p % BLOCK_SIZE) != 0)
        begin
            if (elements[p] > best)
                best = elements[p];
            p++;
        end
        while (p + BLOCK_SIZE <= hi)
        begin
            if (block_peaks[p / BLOCK_SIZE] > best)
                best = block_peaks[p / BLOCK_SIZE];
            p += BLOCK_SIZE;
        end
        while (p <= hi)
        begin
            if (elements[p] > best)
                best = elements[p];
            p++;
        end
        return best;
    endfunction

    function automatic answer_t answer_item(logic op, idx_t left, idx_t right, elem_t value);
        answer_t     a;
        int unsigned limit;
        limit       = count_in_force();
        a.max_value = '0;
        a.status    = ST_OK;
        if (op == OP_WRITE)
        begin
            if (left >= limit)
                a.status = ST_RANGE;
            else
            begin
                elements[left] = value;
                refresh_block(left, limit);
            end
        end
        else if (left >= limit || right >= limit)
            a.status = ST_RANGE;
        else
            a.max_value = span_max(left, right);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ELEMENTS; i++)
                elements[i] = '0;
            for (int i = 0; i < NUM_BLOCKS; i++)
                block_peaks[i] = '0;
            element_count = cnt_t'(MAX_ELEMENTS);
            answers_due.delete();
            fail_tally = 0;
            answers_pending <= 0;
            mismatch_count  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                element_count = cfg_wr_data;
            if (out_ch.valid && out_ch.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("Result transfer with nothing outstanding: max_value %0d, status %0d",
                           out_ch.max_value, out_ch.status);
                    fail_tally++;
                end
                else
                begin
                    oldest = answers_due.pop_front();
                    if (out_ch.max_value !== oldest.max_value)
                    begin
                        $error("max_value mismatch: expected %0d, actual %0d",
                               oldest.max_value, out_ch.max_value);
                        fail_tally++;
                    end
                    if (out_ch.status !== oldest.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.status, out_ch.status);
                        fail_tally++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                answers_due.insert(answers_due.size(),
                                   answer_item(in_ch.op, in_ch.index, in_ch.right_index,
                                               in_ch.value));
            answers_pending <= answers_due.size();
            mismatch_count  <= fail_tally;
        end
    end

endmodule

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmq_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 120;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cnt_t cfg_wr_data;
    int   answers_pending;
    int   mismatch_count;
    int   cycles;
    logic steady;
    logic hold_ask;
    cnt_t count_now;

    rmq_in_if  in_ch ();
    rmq_out_if out_ch ();

    block_range_max_with_update_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    rmq_answer_check answer_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .answers_pending (answers_pending),
        .mismatch_count  (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The receiver stalls in short random bursts unless steady is set; on request it
    // holds off for a long stretch so that the unit backs up and stalls its input.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_ask)
            begin
                out_ch.ready <= 1'b0;
                hold_ask = 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!steady && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic op, input idx_t left, input idx_t right,
                             input elem_t value);
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.index       <= left;
        in_ch.right_index <= right;
        in_ch.value       <= value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
    endtask

    task automatic set_count(input cnt_t c);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        count_now = c;
    endtask

    function automatic elem_t pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return elem_t'($urandom_range(0, 16)) - 8;
            default: return elem_t'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int n, input bit pause_mid);
        int unsigned span;
        logic        op;
        idx_t        left;
        idx_t        right;
        span = (count_now > MAX_ELEMENTS) ? MAX_ELEMENTS : count_now;
        for (int k = 0; k < n; k++)
        begin
            if (pause_mid && k == n / 2)
                wait_drained();
            op = 1'($urandom_range(0, 1));
            if (span == 0 || $urandom_range(0, 9) == 0)
                left = idx_t'($urandom);
            else
                left = idx_t'($urandom_range(0, span - 1));
            case ($urandom_range(0, 9))
                0:       right = idx_t'($urandom);
                1:       right = (left > 0) ? idx_t'($urandom_range(0, left - 1)) : left;
                2, 3, 4:
                begin
                    if (left < span)
                        right = idx_t'($urandom_range(left, span - 1));
                    else
                        right = idx_t'($urandom);
                end
                default:
                begin
                    if (left < span)
                        right = (left + 70 < span) ? left + idx_t'($urandom_range(0, 70))
                                                   : idx_t'($urandom_range(left, span - 1));
                    else
                        right = idx_t'($urandom);
                end
            endcase
            send_item(op, left, right, pick_value());
        end
    endtask

    initial
    begin
        cnt_t phase_counts [11];
        cnt_t c;

        phase_counts = '{11'd1024, 11'd1, 11'd2, 11'd33, 11'd2047, 11'd64, 11'd0,
                         11'd1025, 11'd700, 11'd1, 11'd1024};
        steady   = 1'b0;
        hold_ask = 1'b0;
        count_now = cnt_t'(MAX_ELEMENTS);
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_WRITE;
        in_ch.index       <= '0;
        in_ch.right_index <= '0;
        in_ch.value       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(OP_QUERY, 10'd0, 10'd1023, 32'h5A5A_A5A5);
        send_item(OP_WRITE, 10'd0, 10'd1023, 32'h7FFF_FFFF);
        send_item(OP_WRITE, 10'd1023, 10'd0, 32'h8000_0000);
        send_item(OP_WRITE, 10'd31, 10'd512, -32'sd1);
        send_item(OP_WRITE, 10'd32, 10'd3, 32'sd5);
        send_item(OP_WRITE, 10'd63, 10'd700, -32'sd7);
        send_item(OP_QUERY, 10'd0, 10'd1023, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 10'd1, 10'd1023, 32'h0);
        send_item(OP_QUERY, 10'd1023, 10'd1023, 32'h0);
        send_item(OP_QUERY, 10'd1023, 10'd0, 32'h0);
        send_item(OP_QUERY, 10'd64, 10'd1023, 32'h0);
        send_item(OP_QUERY, 10'd31, 10'd32, 32'h0);
        send_item(OP_QUERY, 10'd33, 10'd63, 32'h0);
        send_item(OP_QUERY, 10'd0, 10'd0, 32'h0);

        set_count(11'd40);
        send_item(OP_WRITE, 10'd35, 10'd0, 32'sd9);
        send_item(OP_WRITE, 10'd40, 10'd0, 32'sd1);
        send_item(OP_QUERY, 10'd0, 10'd40, 32'h0);
        send_item(OP_QUERY, 10'd40, 10'd0, 32'h0);
        send_item(OP_QUERY, 10'd5, 10'd39, 32'h0);

        set_count(11'd0);
        send_item(OP_WRITE, 10'd0, 10'd0, 32'sd3);
        send_item(OP_QUERY, 10'd0, 10'd0, 32'h0);

        set_count(11'd2047);
        send_item(OP_QUERY, 10'd0, 10'd1023, 32'h0);
        send_item(OP_QUERY, 10'd32, 10'd100, 32'h0);
        send_item(OP_WRITE, 10'd1023, 10'd1023, 32'sd3);

        set_count(11'd1025);
        send_item(OP_QUERY, 10'd1000, 10'd1023, 32'h0);

        for (int ph = 0; ph < 11; ph++)
        begin
            c = phase_counts[ph];
            if (ph == 9)
                c = cnt_t'($urandom_range(1, MAX_ELEMENTS));
            set_count(c);
            if (ph == 10)
                steady = 1'b1;
            if (ph == 0)
                hold_ask = 1'b1;
            run_phase((c == 0) ? 20 : PHASE_ITEMS, ph == 5);
        end

        wait_drained();
        repeat (120) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
src/rmq_pkg.sv
src/rmq_if.sv
src/rmq_ram.sv
src/rmq_acc.sv
src/rmq_seq.sv
src/block_range_max_with_update_unit.sv
dv/rmq_answer_check.sv
dv/testbench.sv
